### rtl/dsched_pkg.sv
`default_nettype none

package dsched_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int CYLINDERS = 512;
    localparam int HEADS = 4;
    localparam int SECTORS = 16;

    localparam int CYL_W = 9;
    localparam int HEAD_W = 2;
    localparam int SEC_W = 4;
    localparam int SEEK_W = 4;
    localparam int COST_W = 12;
    localparam int SVC_W = 14;
    localparam int PEND_W = 7;
    localparam int PROD_W = CYL_W + SEEK_W;

    localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(CYLINDERS - 1);
    localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(HEADS - 1);
    localparam logic [SEC_W-1:0] SEC_MAX = SEC_W'(SECTORS - 1);
    localparam logic [SVC_W-1:0] SERVICE_MAX = SVC_W'(16383);

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_SEEK_COST = 2'd1;
    localparam logic [1:0] REG_READ_COST = 2'd2;
    localparam logic [1:0] REG_WRITE_COST = 2'd3;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_SSTF = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CYL_W-1:0]  cylinder;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sector;
        logic              is_write;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CYL_W-1:0]  out_cylinder;
        logic [HEAD_W-1:0] out_head;
        logic [SEC_W-1:0]  out_sector;
        logic              out_write;
        logic [SVC_W-1:0]  service_time;
        logic [PEND_W-1:0] pending;
    } out_t;

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] hd;
        logic [SEC_W-1:0]  sec;
        logic              wr;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [CYL_W-1:0]  span;
        logic [SEEK_W-1:0] seek_cost;
        logic [COST_W-1:0] cost;
    } svc_req_t;

endpackage

`default_nettype wire

### rtl/disk_request_scheduler_sstf.sv
// channel  | signals                     | moves
// ---------+-----------------------------+---------------------------------
// in       | in_valid, in_stall, in_data | enqueue or dispatch request
// out      | out_valid, out_stall, out_data | one result per request
// cfg      | cfg_we, cfg_index, cfg_data | policy and cost registers
//
// enqueue, rejection and empty dispatch results pass through res_reg to the output register.
// a dispatch scans the waiting entries (only the oldest in arrival order), closes the gap,
// then waits for the service time; scan and close-up each make one table read per cycle.
// reset clears count, puts the head at cylinder 1 and loads default policy and costs; the table is not cleared.
// a new request is taken while a result waits on a stalled output; its own result
// then holds in_stall high until the output register frees.
`default_nettype none

module disk_request_scheduler_sstf #(
    parameter int QUEUE_DEPTH = dsched_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire dsched_pkg::in_t             in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output dsched_pkg::out_t                 out_data,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [dsched_pkg::COST_W-1:0] cfg_data
);
    import dsched_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CYL_W-1:0]  head_reg, head_next;
    logic              policy_reg;
    logic [SEEK_W-1:0] seek_reg;
    logic [COST_W-1:0] rcost_reg;
    logic [COST_W-1:0] wcost_reg;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;
    out_t              res_reg, res_next;

    logic [AW-1:0]     last_reg, last_next;
    logic [CW-1:0]     sc_issue_reg, sc_issue_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CYL_W-1:0]  best_reg, best_next;
    logic [AW-1:0]     pick_reg, pick_next;
    entry_t            chosen_reg, chosen_next;
    logic [CW-1:0]     sh_src_reg, sh_src_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              enq_we;
    entry_t            enq_entry;
    logic [CYL_W-1:0]  seek_dist;
    logic              take;
    logic [AW-1:0]     pick_sel;
    logic              in_acc;

    svc_req_t          svc_req;
    logic              svc_done;
    logic [SVC_W-1:0]  svc_value;

    dsched_svc u_svc (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (svc_req),
        .done    (svc_done),
        .service (svc_value)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        enq_entry.cyl = (in_data.cylinder > CYL_MAX) ? CYL_MAX : in_data.cylinder;
        enq_entry.hd  = (in_data.head > HEAD_MAX) ? HEAD_MAX : in_data.head;
        enq_entry.sec = (in_data.sector > SEC_MAX) ? SEC_MAX : in_data.sector;
        enq_entry.wr  = in_data.is_write;
    end

    assign seek_dist = (head_reg > rd_data.cyl) ? (head_reg - rd_data.cyl)
                                                : (rd_data.cyl - head_reg);
    assign take = (cmp_idx_reg == '0) || (seek_dist < best_reg);
    assign pick_sel = take ? cmp_idx_reg : pick_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        sc_issue_next  = sc_issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        chosen_next    = chosen_reg;
        sh_src_next    = sh_src_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        enq_we         = 1'b0;
        svc_req.start     = 1'b0;
        svc_req.span      = best_reg;
        svc_req.seek_cost = seek_reg;
        svc_req.cost      = chosen_reg.wr ? wcost_reg : rcost_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_next = '0;
                    if (in_data.cmd == CMD_ENQUEUE)
                    begin
                        if (count_reg >= CW'(QUEUE_DEPTH))
                        begin
                            res_next.status  = ST_FULL;
                            res_next.pending = PEND_W'(count_reg);
                        end
                        else
                        begin
                            enq_we           = 1'b1;
                            count_next       = count_reg + CW'(1);
                            res_next.status  = ST_ENQUEUED;
                            res_next.pending = PEND_W'(count_reg + CW'(1));
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status  = ST_EMPTY;
                        res_next.pending = '0;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        last_next     = (policy_reg == POLICY_SSTF) ? AW'(count_reg - CW'(1))
                                                                    : '0;
                        sc_issue_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // one read per cycle, compare in the cycle after its read
                if (sc_issue_reg <= CW'(last_reg))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = sc_issue_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = sc_issue_reg[AW-1:0];
                    sc_issue_next  = sc_issue_reg + CW'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (take)
                    begin
                        best_next   = seek_dist;
                        pick_next   = cmp_idx_reg;
                        chosen_next = rd_data;
                    end
                    if (cmp_idx_reg == last_reg)
                    begin
                        sh_src_next = CW'(pick_sel) + CW'(1);
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // close the gap: read entry i+1, write it to i next cycle
                if (sh_src_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = sh_src_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = AW'(sh_src_reg - CW'(1));
                    sh_src_next  = sh_src_reg + CW'(1);
                end
                else
                begin
                    svc_req.start         = 1'b1;
                    count_next            = count_reg - CW'(1);
                    head_next             = chosen_reg.cyl;
                    res_next.status       = ST_DISPATCHED;
                    res_next.out_cylinder = chosen_reg.cyl;
                    res_next.out_head     = chosen_reg.hd;
                    res_next.out_sector   = chosen_reg.sec;
                    res_next.out_write    = chosen_reg.wr;
                    res_next.pending      = PEND_W'(count_reg - CW'(1));
                    state_next            = S_CALC;
                end
            end
            S_CALC:
            begin
                if (svc_done)
                begin
                    res_next.service_time = svc_value;
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // request table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= rd_data;
        end
        else if (enq_we)
        begin
            mem[count_reg[AW-1:0]] <= enq_entry;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= CYL_W'(1);
            policy_reg    <= POLICY_SSTF;
            seek_reg      <= SEEK_W'(1);
            rcost_reg     <= COST_W'(120);
            wcost_reg     <= COST_W'(240);
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLICY:     policy_reg <= cfg_data[0];
                    REG_SEEK_COST:  seek_reg   <= cfg_data[SEEK_W-1:0];
                    REG_READ_COST:  rcost_reg  <= cfg_data;
                    REG_WRITE_COST: wcost_reg  <= cfg_data;
                    default:        policy_reg <= policy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        res_reg      <= res_next;
        last_reg     <= last_next;
        sc_issue_reg <= sc_issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        chosen_reg   <= chosen_next;
        sh_src_reg   <= sh_src_next;
        wr_addr_reg  <= wr_addr_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan with empty table");

    a_shift_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (CW'(wr_addr_reg) + CW'(1) < count_reg + CW'(1)))
        else $error("close-up write outside pending entries");

    a_svc_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        svc_done |-> (state_reg == S_CALC))
        else $error("service time ready outside calc");

    a_dispatch_drops_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && state_next == S_CALC) |=>
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("dispatch did not remove an entry");

endmodule

`default_nettype wire

### rtl/dsched_svc.sv
`default_nettype none

module dsched_svc (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dsched_pkg::svc_req_t      req,
    output logic                           done,
    output logic [dsched_pkg::SVC_W-1:0]   service
);
    import dsched_pkg::*;

    logic              v1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [COST_W-1:0] cost_reg;
    logic              done_reg;
    logic [SVC_W-1:0]  service_reg;
    logic [SVC_W:0]    sum;

    // seek product first, then read or write cost and saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_W'(req.span) * PROD_W'(req.seek_cost);
        cost_reg    <= req.cost;
        service_reg <= (sum > (SVC_W+1)'(SERVICE_MAX)) ? SERVICE_MAX : sum[SVC_W-1:0];
    end

    assign sum     = (SVC_W+1)'(prod_reg) + (SVC_W+1)'(cost_reg);
    assign done    = done_reg;
    assign service = service_reg;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dsched_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_t                in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_t               out_data;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_POLICY;
    logic [COST_W-1:0]  cfg_data = '0;

    // scheduler state as the testbench sees it
    entry_t             slots [QUEUE_DEPTH_DEF];
    int                 slot_count = 0;
    int                 arm_cyl = 1;
    logic               cfg_policy = POLICY_SSTF;
    logic [SEEK_W-1:0]  cfg_seek = 4'd1;
    logic [COST_W-1:0]  cfg_read = 12'd120;
    logic [COST_W-1:0]  cfg_write = 12'd240;

    in_t                request_q [$];
    out_t               outcome_q [$];
    int                 requests_queued = 0;
    int                 requests_taken = 0;
    int                 mismatches = 0;
    int                 send_gap = 0;
    int                 send_calm = 0;
    int                 stall_left = 0;
    int                 recv_calm = 0;

    disk_request_scheduler_sstf dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int seek_span(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic out_t schedule_request(in_t req);
        out_t   res;
        entry_t chosen;
        int     pick;
        int     best;
        int     span;
        int     cost;
        res = '0;
        if (req.cmd == CMD_ENQUEUE)
        begin
            if (slot_count >= QUEUE_DEPTH_DEF)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                slots[slot_count].cyl = (req.cylinder > CYL_MAX) ? CYL_MAX : req.cylinder;
                slots[slot_count].hd = (req.head > HEAD_MAX) ? HEAD_MAX : req.head;
                slots[slot_count].sec = (req.sector > SEC_MAX) ? SEC_MAX : req.sector;
                slots[slot_count].wr = req.is_write;
                slot_count++;
                res.status = ST_ENQUEUED;
            end
        end
        else if (slot_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            pick = 0;
            if (cfg_policy == POLICY_SSTF)
            begin
                // nearest cylinder, earliest entry on a tie
                best = seek_span(arm_cyl, slots[0].cyl);
                for (int i = 1; i < slot_count; i++)
                begin
                    span = seek_span(arm_cyl, slots[i].cyl);
                    if (span < best)
                    begin
                        best = span;
                        pick = i;
                    end
                end
            end
            chosen = slots[pick];
            cost = seek_span(arm_cyl, chosen.cyl) * cfg_seek
                   + (chosen.wr ? cfg_write : cfg_read);
            res.service_time = (cost > SERVICE_MAX) ? SERVICE_MAX : SVC_W'(cost);
            for (int i = pick; i + 1 < slot_count; i++)
            begin
                slots[i] = slots[i + 1];
            end
            slot_count--;
            arm_cyl = chosen.cyl;
            res.status = ST_DISPATCHED;
            res.out_cylinder = chosen.cyl;
            res.out_head = chosen.hd;
            res.out_sector = chosen.sec;
            res.out_write = chosen.wr;
        end
        res.pending = PEND_W'(slot_count);
        return res;
    endfunction

    function automatic int next_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(30, 80);
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t make_request(logic cmd);
        in_t r;
        r.cmd = cmd;
        case ($urandom_range(0, 9))
            0: r.cylinder = '0;
            1: r.cylinder = CYL_MAX;
            2, 3, 4: r.cylinder = CYL_W'($urandom_range(96, 104));
            default: r.cylinder = CYL_W'($urandom);
        endcase
        r.head = HEAD_W'($urandom);
        r.sector = SEC_W'($urandom);
        r.is_write = 1'($urandom);
        return r;
    endfunction

    function automatic logic [COST_W-1:0] draw_setting(int top);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COST_W'(top);
            default: return COST_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_outcome(out_t got, out_t want);
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.out_cylinder !== want.out_cylinder)
            report_mismatch($sformatf("out_cylinder got %0d want %0d",
                                      got.out_cylinder, want.out_cylinder));
        if (got.out_head !== want.out_head)
            report_mismatch($sformatf("out_head got %0d want %0d",
                                      got.out_head, want.out_head));
        if (got.out_sector !== want.out_sector)
            report_mismatch($sformatf("out_sector got %0d want %0d",
                                      got.out_sector, want.out_sector));
        if (got.out_write !== want.out_write)
            report_mismatch($sformatf("out_write got %0d want %0d",
                                      got.out_write, want.out_write));
        if (got.service_time !== want.service_time)
            report_mismatch($sformatf("service_time got %0d want %0d",
                                      got.service_time, want.service_time));
        if (got.pending !== want.pending)
            report_mismatch($sformatf("pending got %0d want %0d", got.pending, want.pending));
    endtask

    task automatic queue_request(in_t r);
        request_q = {request_q, r};
        requests_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (requests_taken != requests_queued || outcome_q.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COST_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLICY: cfg_policy = value[0];
            REG_SEEK_COST: cfg_seek = value[SEEK_W-1:0];
            REG_READ_COST: cfg_read = value;
            REG_WRITE_COST: cfg_write = value;
        endcase
    endtask

    // narrow registers get junk in the unused upper bits
    task automatic apply_settings(logic pol, logic [SEEK_W-1:0] seek,
                                  logic [COST_W-1:0] rd, logic [COST_W-1:0] wr);
        write_reg(REG_POLICY, {11'($urandom), pol});
        write_reg(REG_SEEK_COST, {8'($urandom), seek});
        write_reg(REG_READ_COST, rd);
        write_reg(REG_WRITE_COST, wr);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q = {outcome_q, schedule_request(in_data)};
                requests_taken++;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= request_q.pop_front();
                    send_gap = next_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                    compare_outcome(out_data, outcome_q.pop_front());
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = next_gap(recv_calm);
            end
        end
    end

    initial
    begin
        int count;
        int burst;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty dispatch, exact hit, tie, far seek
        queue_request(in_t'{CMD_DISPATCH, 9'd7, 2'd1, 4'd3, 1'b1});
        queue_request(in_t'{CMD_ENQUEUE, 9'd0, 2'd0, 4'd0, 1'b0});
        queue_request(in_t'{CMD_ENQUEUE, 9'd2, 2'd3, 4'd15, 1'b1});
        queue_request(in_t'{CMD_ENQUEUE, 9'd511, 2'd3, 4'd15, 1'b1});
        queue_request(in_t'{CMD_ENQUEUE, 9'd1, 2'd1, 4'd5, 1'b0});
        repeat (5) queue_request(in_t'{CMD_DISPATCH, 9'd0, 2'd0, 4'd0, 1'b0});
        wait_idle();

        // arrival order with the largest costs
        apply_settings(POLICY_FIFO, 4'd15, 12'd4095, 12'd4095);
        queue_request(in_t'{CMD_ENQUEUE, 9'd0, 2'd2, 4'd9, 1'b0});
        queue_request(in_t'{CMD_ENQUEUE, 9'd510, 2'd1, 4'd6, 1'b1});
        queue_request(in_t'{CMD_ENQUEUE, 9'd509, 2'd0, 4'd10, 1'b0});
        repeat (4) queue_request(in_t'{CMD_DISPATCH, 9'd511, 2'd3, 4'd15, 1'b1});
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_settings(POLICY_SSTF, 4'd0, 12'd0, 12'd0);
                1: apply_settings(POLICY_SSTF, 4'd15, draw_setting(4095), draw_setting(4095));
                default: apply_settings($urandom_range(0, 1) ? POLICY_SSTF : POLICY_FIFO,
                                        SEEK_W'(draw_setting(15)),
                                        draw_setting(4095), draw_setting(4095));
            endcase
            case (phase % 3)
                0:
                begin
                    for (count = 0; count < 136; count++)
                    begin
                        if (count == 68)
                            wait_idle();
                        queue_request(make_request(($urandom_range(0, 99) < 55)
                                                   ? CMD_ENQUEUE : CMD_DISPATCH));
                    end
                end
                1:
                begin
                    // overfill the table, then drain it past empty
                    repeat (70) queue_request(make_request(CMD_ENQUEUE));
                    repeat (72) queue_request(make_request(CMD_DISPATCH));
                end
                default:
                begin
                    count = 0;
                    while (count < 136)
                    begin
                        burst = $urandom_range(1, 24);
                        repeat (burst) queue_request(make_request(CMD_ENQUEUE));
                        count += burst;
                        burst = $urandom_range(1, 24);
                        repeat (burst) queue_request(make_request(CMD_DISPATCH));
                        count += burst;
                    end
                end
            endcase
            wait_idle();
        end

        repeat (2 * QUEUE_DEPTH_DEF + 10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/dsched_pkg.sv
rtl/dsched_svc.sv
rtl/disk_request_scheduler_sstf.sv
dv/tb_top.sv
